[rtl/cphit_pkg.sv]
// Shared constants for the circle pick hit test unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package cphit_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;

   // register index decode
   localparam int REG_IDX_WIDTH = 3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_X  = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_Y  = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_CENTER_Z  = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_RADIUS    = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_TOLERANCE = 3'd4;

   // flags riding along with a pick through the divider
   typedef struct packed {
      logic hit;
      logic at_center;
      logic neg_x;
      logic neg_y;
   } pick_flags_type;

endpackage

`default_nettype wire

[rtl/cphit_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, with remainder.
// Standalone; used by circle_pick_hit_test_unit.
`timescale 1ns / 1ps
`default_nettype none

module cphit_sqrt_pipe #(
   parameter int RW = 34,
   parameter int SW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            enable,
   input  wire logic            in_valid,
   input  wire logic [2*RW-1:0] in_radicand,
   input  wire logic [SW-1:0]   in_side,
   output logic                 out_valid,
   output logic [RW-1:0]        out_root,
   output logic [RW+2:0]        out_rem,
   output logic [SW-1:0]        out_side
);

   localparam int REMW = RW + 3;

   logic            valid_ff [RW];
   logic [RW-1:0]   root_ff  [RW];
   logic [REMW-1:0] rem_ff   [RW];
   logic [2*RW-1:0] rad_ff   [RW-1];
   logic [SW-1:0]   side_ff  [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic            valid_prev;
      logic [RW-1:0]   root_prev;
      logic [REMW-1:0] rem_prev;
      logic [2*RW-1:0] rad_prev;
      logic [SW-1:0]   side_prev;
      logic [REMW-1:0] rem_shift;
      logic [REMW-1:0] trial;
      logic            take;
      logic [RW-1:0]   root_in;
      logic [REMW-1:0] rem_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign root_prev  = '0;
         assign rem_prev   = '0;
         assign rad_prev   = in_radicand;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign rad_prev   = rad_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_shift = {rem_prev[REMW-3:0], rad_prev[2*RW-1 -: 2]};
      assign trial     = {1'b0, root_prev, 2'b01};
      assign take      = rem_shift >= trial;
      assign root_in   = {root_prev[RW-2:0], take};
      assign rem_in    = take ? (rem_shift - trial) : rem_shift;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[s] <= root_in;
            rem_ff[s]  <= rem_in;
            side_ff[s] <= side_prev;
         end
      end

      if (s < RW - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (enable) begin
               rad_ff[s] <= {rad_prev[2*RW-3:0], 2'b00};
            end
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_rem   = rem_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

[rtl/cphit_div_pipe.sv]
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage.
// Standalone; used by circle_pick_hit_test_unit.
`timescale 1ns / 1ps
`default_nettype none

module cphit_div_pipe #(
   parameter int QW = 32,
   parameter int DW = 34,
   parameter int SW = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic                in_valid,
   input  wire logic [DW-1:0]       in_den,
   input  wire logic [1:0][DW-1:0]  in_rem,   // dividend high part, below in_den
   input  wire logic [1:0][QW-1:0]  in_low,   // dividend low part
   input  wire logic [SW-1:0]       in_side,
   output logic                     out_valid,
   output logic [DW-1:0]            out_den,
   output logic [1:0][QW-1:0]       out_quo,
   output logic [1:0][DW-1:0]       out_rem,
   output logic [SW-1:0]            out_side
);

   logic                valid_ff [QW];
   logic [DW-1:0]       den_ff   [QW];
   logic [1:0][DW-1:0]  rem_ff   [QW];
   logic [1:0][QW-1:0]  low_ff   [QW];   // dividend bits out, quotient bits in
   logic [SW-1:0]       side_ff  [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic               valid_prev;
      logic [DW-1:0]      den_prev;
      logic [1:0][DW-1:0] rem_prev;
      logic [1:0][QW-1:0] low_prev;
      logic [SW-1:0]      side_prev;
      logic [1:0][DW-1:0] rem_in;
      logic [1:0][QW-1:0] low_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign den_prev   = in_den;
         assign rem_prev   = in_rem;
         assign low_prev   = in_low;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign low_prev   = low_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      always_comb begin
         logic [DW:0] rem_shift;
         logic [DW:0] diff;
         logic        ge;
         for (int l = 0; l < 2; l++) begin
            rem_shift = {rem_prev[l], low_prev[l][QW-1]};
            diff      = rem_shift - {1'b0, den_prev};
            ge        = rem_shift >= {1'b0, den_prev};
            rem_in[l] = ge ? diff[DW-1:0] : rem_shift[DW-1:0];
            low_in[l] = {low_prev[l][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[s]  <= den_prev;
            rem_ff[s]  <= rem_in;
            low_ff[s]  <= low_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_den   = den_ff[QW-1];
   assign out_quo   = low_ff[QW-1];
   assign out_rem   = rem_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire

[rtl/circle_pick_hit_test_unit.sv]
// Top level of the circle pick hit test: CSR block, front end, sqrt and divider pipes, output.
// Depends on cphit_pkg, cphit_sqrt_pipe and cphit_div_pipe.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | ports  | moves
//  ---------+--------+--------------------------------------------------
//  input    | req_*  | pick point transfer (pick_x, pick_y)
//  result   | rsp_*  | hit in tuser; gap, near_x, near_y, near_z in tdata
//  config   | csr_*  | APB writes/reads of center, radius, tolerance
//
//  One transfer in and one out per cycle sustained while rsp_tready is high. The
//  pipeline is 3 front stages, COORD_WIDTH+2 square-root stages,
//  one stage for rounding/gap/products, COORD_WIDTH divider stages, one output.
//  Reset clears the valid bits and the config registers (all zero).
//  A stall on rsp_tready freezes every stage at once; req_tready follows it.

module circle_pick_hit_test_unit #(
   parameter int COORD_WIDTH = cphit_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,

   input  wire logic  req_tvalid,
   output logic       req_tready,
   // [pick_x, pick_y] from bit 0 up, zero pad to bytes
   input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,

   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   // [gap, near_x, near_y, near_z] from bit 0 up, zero pad to bytes
   output logic [((4*COORD_WIDTH+6)/8)*8-1:0] rsp_tdata,
   // [hit]
   output logic       rsp_tuser,

   input  wire logic  csr_psel,
   input  wire logic  csr_penable,
   input  wire logic  csr_pwrite,
   input  wire logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0]   csr_paddr,
   input  wire logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]      csr_prdata,
   output logic       csr_pready
);

   import cphit_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int RW     = W + 2;                  // sqrt root / divisor width
   localparam int RSP_DW = ((4*W+6)/8)*8;
   localparam int CSR_DW = (W > 32) ? 64 : 32;
   localparam int CSR_AW = (W > 32) ? 6 : 5;
   localparam int SQ_SW  = 2 + 2*(W+1);            // signs and magnitudes
   localparam int DV_SW  = $bits(pick_flags_type) + RW;

   // ---------------- configuration registers ----------------
   logic [W-1:0] cx_ff, cy_ff, cz_ff;
   logic [W-2:0] rad_ff, tol_ff;
   logic [REG_IDX_WIDTH-1:0] csr_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1 -: REG_IDX_WIDTH];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= '0;
         tol_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CENTER_X:  cx_ff  <= csr_pwdata[W-1:0];
            REG_CENTER_Y:  cy_ff  <= csr_pwdata[W-1:0];
            REG_CENTER_Z:  cz_ff  <= csr_pwdata[W-1:0];
            REG_RADIUS:    rad_ff <= csr_pwdata[W-2:0];
            REG_TOLERANCE: tol_ff <= csr_pwdata[W-2:0];
            default: ;   // writes past the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_CENTER_X:  csr_prdata = CSR_DW'(cx_ff);
         REG_CENTER_Y:  csr_prdata = CSR_DW'(cy_ff);
         REG_CENTER_Z:  csr_prdata = CSR_DW'(cz_ff);
         REG_RADIUS:    csr_prdata = CSR_DW'(rad_ff);
         REG_TOLERANCE: csr_prdata = CSR_DW'(tol_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline advance ----------------
   // every stage moves together; output register frees on transfer
   logic rsp_valid_ff;
   logic adv;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: differences to the center
   logic         v1_ff;
   logic [W:0]   dx1_ff, dy1_ff;
   logic [W-1:0] pick_x, pick_y;
   assign pick_x = req_tdata[W-1:0];
   assign pick_y = req_tdata[2*W-1:W];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff <= {pick_x[W-1], pick_x} - {cx_ff[W-1], cx_ff};
         dy1_ff <= {pick_y[W-1], pick_y} - {cy_ff[W-1], cy_ff};
      end
   end

   // stage 2: magnitudes and squares
   logic           v2_ff;
   logic [W:0]     ax_in, ay_in, ax2_ff, ay2_ff;
   logic           negx2_ff, negy2_ff;
   logic [2*W+1:0] sqx2_ff, sqy2_ff;
   assign ax_in = dx1_ff[W] ? ((W+1)'(0) - dx1_ff) : dx1_ff;
   assign ay_in = dy1_ff[W] ? ((W+1)'(0) - dy1_ff) : dy1_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ax2_ff   <= ax_in;
         ay2_ff   <= ay_in;
         negx2_ff <= dx1_ff[W];
         negy2_ff <= dy1_ff[W];
         sqx2_ff  <= ax_in * ax_in;
         sqy2_ff  <= ay_in * ay_in;
      end
   end

   // stage 3: sum of squares (Q.32 distance squared)
   logic             v3_ff;
   logic [2*RW-1:0]  rad3_ff;
   logic [SQ_SW-1:0] side3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rad3_ff  <= (2*RW)'(sqx2_ff) + (2*RW)'(sqy2_ff);
         side3_ff <= {negx2_ff, negy2_ff, ax2_ff, ay2_ff};
      end
   end

   // square root pipe
   logic             sq_valid;
   logic [RW-1:0]    sq_root;
   logic [RW+2:0]    sq_rem;
   logic [SQ_SW-1:0] sq_side;

   cphit_sqrt_pipe #(
      .RW (RW),
      .SW (SQ_SW)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (adv),
      .in_valid    (v3_ff),
      .in_radicand (rad3_ff),
      .in_side     (side3_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_rem     (sq_rem),
      .out_side    (sq_side)
   );

   // stage 4: round d (half up: rem > root), gap, hit, radius products
   logic           v4_ff;
   logic [RW-1:0]  d_in, gap_in;
   logic [W:0]     sax, say;
   logic [RW-1:0]  d4_ff;
   logic [2*W-1:0] prx4_ff, pry4_ff;
   pick_flags_type flags4_ff;
   logic [RW-1:0]  gap4_ff;

   assign sax    = sq_side[2*W+1:W+1];
   assign say    = sq_side[W:0];
   assign d_in   = sq_root + RW'(sq_rem > (RW+3)'(sq_root));
   assign gap_in = (d_in >= RW'(rad_ff)) ? (d_in - RW'(rad_ff)) : (RW'(rad_ff) - d_in);

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= sq_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d4_ff               <= d_in;
         gap4_ff             <= gap_in;
         flags4_ff.hit       <= gap_in <= RW'(tol_ff);
         flags4_ff.at_center <= d_in == '0;
         flags4_ff.neg_x     <= sq_side[SQ_SW-1];
         flags4_ff.neg_y     <= sq_side[SQ_SW-2];
         prx4_ff             <= (2*W)'(rad_ff) * (2*W)'(sax);
         pry4_ff             <= (2*W)'(rad_ff) * (2*W)'(say);
      end
   end

   // divider pipe: radius * |delta| / d, both axes
   logic               dv_valid;
   logic [RW-1:0]      dv_den;
   logic [1:0][W-1:0]  dv_quo;
   logic [1:0][RW-1:0] dv_rem;
   logic [DV_SW-1:0]   dv_side;
   logic [1:0][RW-1:0] dv_rem_init;
   logic [1:0][W-1:0]  dv_low_init;

   assign dv_rem_init[0] = RW'(prx4_ff[2*W-1:W]);
   assign dv_rem_init[1] = RW'(pry4_ff[2*W-1:W]);
   assign dv_low_init[0] = prx4_ff[W-1:0];
   assign dv_low_init[1] = pry4_ff[W-1:0];

   cphit_div_pipe #(
      .QW (W),
      .DW (RW),
      .SW (DV_SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v4_ff),
      .in_den    (d4_ff),
      .in_rem    (dv_rem_init),
      .in_low    (dv_low_init),
      .in_side   ({flags4_ff, gap4_ff}),
      .out_valid (dv_valid),
      .out_den   (dv_den),
      .out_quo   (dv_quo),
      .out_rem   (dv_rem),
      .out_side  (dv_side)
   );

   // stage 5: round quotients, add to center, saturate, blank on miss
   pick_flags_type   dv_flags;
   logic [RW-1:0]    dv_gap;
   logic [1:0][W:0]  q_rnd;
   logic [1:0][W+1:0] near_sum;
   logic [1:0][W-1:0] near_sat;
   logic [W-2:0]     gap_sat;

   assign dv_flags = dv_side[DV_SW-1 -: $bits(pick_flags_type)];
   assign dv_gap   = dv_side[RW-1:0];

   always_comb begin
      logic [W+1:0] ctr;
      logic [W+1:0] off;
      logic         neg;
      for (int l = 0; l < 2; l++) begin
         q_rnd[l] = (W+1)'(dv_quo[l])
                  + (W+1)'({dv_rem[l], 1'b0} >= {1'b0, dv_den});
         neg = (l == 0) ? dv_flags.neg_x : dv_flags.neg_y;
         ctr = (l == 0) ? {{2{cx_ff[W-1]}}, cx_ff} : {{2{cy_ff[W-1]}}, cy_ff};
         off = neg ? ((W+2)'(0) - (W+2)'(q_rnd[l])) : (W+2)'(q_rnd[l]);
         // point at the center: nearest point is (cx + radius, cy)
         if (dv_flags.at_center) begin
            off = (l == 0) ? (W+2)'(rad_ff) : '0;
         end
         near_sum[l] = ctr + off;
         // fits when the top three bits agree
         if (near_sum[l][W+1:W-1] == 3'b000 || near_sum[l][W+1:W-1] == 3'b111) begin
            near_sat[l] = near_sum[l][W-1:0];
         end else if (near_sum[l][W+1]) begin
            near_sat[l] = {1'b1, {(W-1){1'b0}}};
         end else begin
            near_sat[l] = {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   assign gap_sat = (|dv_gap[RW-1:W-1]) ? {(W-1){1'b1}} : dv_gap[W-2:0];

   logic         hit_ff;
   logic [W-2:0] gap_ff;
   logic [W-1:0] nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= dv_flags.hit;
         gap_ff <= dv_flags.hit ? gap_sat : '0;
         nx_ff  <= dv_flags.hit ? near_sat[0] : '0;
         ny_ff  <= dv_flags.hit ? near_sat[1] : '0;
         nz_ff  <= dv_flags.hit ? cz_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = RSP_DW'({nz_ff, ny_ff, nx_ff, gap_ff});

endmodule

`default_nettype wire

[sim/circle_pick_hit_test_unit_test.sv]
// Testbench for circle_pick_hit_test_unit: APB setup of the circle, streamed pick points,
// result stream checked against a built-in distance and nearest-point predictor.
// Depends on cphit_pkg and circle_pick_hit_test_unit.
`timescale 1ns / 1ps

module circle_pick_hit_test_unit_test;
   import cphit_pkg::*;

   localparam int W = 32;
   localparam int LATENCY = 2*W+7;

   typedef struct packed {
      logic        hit;
      logic [30:0] gap;
      logic [31:0] near_x;
      logic [31:0] near_y;
      logic [31:0] near_z;
   } hit_result_t;

   typedef struct packed {
      logic [31:0] pick_y;
      logic [31:0] pick_x;
   } pick_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   circle_pick_hit_test_unit #(.COORD_WIDTH(W)) dut (.*);

   always #5 clock = ~clock;

   // predictor copy of the registers
   logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
   logic [30:0] radius = 0, tolerance = 0;

   pick_t       pick_queue[$];
   hit_result_t expected_hits[$];
   int  errors = 0;
   bit  quiet_driver = 0;  // long stretch with no idling
   bit  quiet_sink = 0;
   bit  req_taken = 0;     // input transfer at the last rising edge

   function automatic logic [63:0] isqrt_round(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      if (n > {64'd0, r} * {64'd0, r} + {64'd0, r}) r = r + 1;
      return r;
   endfunction

   // rad*|delta|/d rounded to nearest, ties away, signed like delta
   function automatic logic signed [65:0] scaled_offset(logic [30:0] rad,
                                                         logic signed [33:0] delta,
                                                         logic [63:0] d);
      logic [127:0] num, q, rem;
      logic [33:0] mag;
      mag = delta < 0 ? -delta : delta;
      num = {97'd0, rad} * {94'd0, mag};
      q = num / d;
      rem = num % d;
      if (rem >= {64'd0, d} - rem) q = q + 1;
      return delta < 0 ? -$signed({1'b0, q[64:0]}) : $signed({1'b0, q[64:0]});
   endfunction

   function automatic logic [31:0] clamp_coord(logic signed [67:0] v);
      if (v > 68'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -68'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic hit_result_t predict_hit(pick_t p);
      hit_result_t res;
      logic signed [33:0] dx, dy;
      logic [33:0] ax, ay;
      logic [127:0] sumsq;
      logic [63:0] d, gap;
      res = '0;
      dx = $signed(p.pick_x) - center_x;
      dy = $signed(p.pick_y) - center_y;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sumsq = {94'd0, ax} * {94'd0, ax} + {94'd0, ay} * {94'd0, ay};
      d = isqrt_round(sumsq);
      gap = d >= radius ? d - radius : radius - d;
      if (gap > tolerance) return res;  // miss: everything zero
      res.hit = 1;
      res.gap = gap > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : gap[30:0];
      res.near_z = center_z;
      if (d == 0) begin
         // point at center: nearest point taken along +x
         res.near_x = clamp_coord(68'(center_x) + 68'(radius));
         res.near_y = center_y;
      end else begin
         res.near_x = clamp_coord(68'(center_x) + 68'(scaled_offset(radius, dx, d)));
         res.near_y = clamp_coord(68'(center_y) + 68'(scaled_offset(radius, dy, d)));
      end
      return res;
   endfunction

   always @(posedge clock)
      req_taken <= req_tvalid && req_tready;

   // driver: one transfer per handshake, random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (pick_queue.size() > 0 && (quiet_driver || $urandom_range(99) >= 8)) begin
            req_tvalid <= 1;
            req_tdata <= pick_queue[0];
            expected_hits.insert(expected_hits.size(), predict_hit(pick_queue[0]));
            void'(pick_queue.pop_front());
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= !reset && (quiet_sink || $urandom_range(99) >= 8);

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      hit_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[30:0], rsp_tdata[62:31], rsp_tdata[94:63],
                rsp_tdata[126:95]};
         if (expected_hits.size() == 0) begin
            $display("%0t: result with none expected: %h", $time, got);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit)
               $display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
            if (got.gap !== want.gap)
               $display("%0t: gap exp %h got %h", $time, want.gap, got.gap);
            if (got.near_x !== want.near_x)
               $display("%0t: near_x exp %h got %h", $time, want.near_x, got.near_x);
            if (got.near_y !== want.near_y)
               $display("%0t: near_y exp %h got %h", $time, want.near_y, got.near_y);
            if (got.near_z !== want.near_z)
               $display("%0t: near_z exp %h got %h", $time, want.near_z, got.near_z);
            if (got !== want) errors++;
         end
      end
   end

   task automatic csr_write(logic [REG_IDX_WIDTH-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_CENTER_X:  center_x = value;
         REG_CENTER_Y:  center_y = value;
         REG_CENTER_Z:  center_z = value;
         REG_RADIUS:    radius = value[30:0];
         REG_TOLERANCE: tolerance = value[30:0];
         default: ;
      endcase
   endtask

   task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad, logic [31:0] tol);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS, rad);
      csr_write(REG_TOLERANCE, tol);
   endtask

   task automatic drain;
      wait (pick_queue.size() == 0 && !req_tvalid && expected_hits.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(logic signed [31:0] around, int spread);
      // spread 0 means fully random
      if (spread == 0) return $urandom;
      return around + $signed($urandom_range(2*spread) - spread);
   endfunction

   task automatic add_pick(logic [31:0] x, logic [31:0] y);
      pick_t p;
      p.pick_x = x;
      p.pick_y = y;
      pick_queue.insert(pick_queue.size(), p);
   endtask

   initial begin
      logic [31:0] px, py, rad;
      int spread;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 0;

      // directed: unit circle at origin, generous tolerance
      set_circle(0, 0, 32'h0003_0000, 32'h0001_0000, 32'h0000_8000);
      add_pick(0, 0);                        // point at center
      add_pick(32'h0001_0000, 0);
      add_pick(0, 32'hFFFF_0000);
      add_pick(32'h0000_B505, 32'h0000_B505);
      add_pick(32'hFFFF_4AFB, 32'h0000_B505);
      add_pick(32'h0005_0000, 0);            // miss
      add_pick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_pick(32'h8000_0000, 32'h8000_0000);
      add_pick(32'h8000_0000, 32'h7FFF_FFFF);
      drain();
      // extremes: huge radius and tolerance, corner center, saturation
      set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_pick(32'h7FFF_FFFF, 32'h8000_0000);
      add_pick(32'h8000_0000, 32'h7FFF_FFFF);
      add_pick(32'h8000_0000, 32'h8000_0000);
      add_pick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_pick(0, 0);
      add_pick(32'hFFFF_FFFF, 32'h5555_5555);
      drain();
      set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      add_pick(32'h8000_0000, 32'h7FFF_FFFF);
      add_pick(32'h8000_0001, 32'h7FFF_FFFF);
      add_pick(32'hAAAA_AAAA, 32'h5555_5555);
      drain();

      // random phases: points mostly near the circle so hits dominate
      for (int phase = 0; phase < 14; phase++) begin
         rad = (phase % 4 == 0) ? $urandom & 32'h7FFF_FFFF : $urandom_range(32'h0100_0000);
         set_circle($urandom, $urandom, $urandom, rad, $urandom_range(phase == 13 ? 0 : 32'h40000));
         if (phase == 5) begin
            quiet_driver = 1; quiet_sink = 1;
         end
         if (phase == 7) begin
            quiet_driver = 0; quiet_sink = 0;
         end
         for (int i = 0; i < 100; i++) begin
            spread = (i % 10 == 0) ? 0 : 32'h0004_0000;
            if (spread == 0) begin
               px = $urandom; py = $urandom;
            end else begin
               // pick on the circle at a random direction, then jitter
               real ang;
               ang = $urandom_range(6283) / 1000.0;
               px = center_x + $rtoi($itor(radius) * $cos(ang));
               py = center_y + $rtoi($itor(radius) * $sin(ang));
               px = rand_coord(px, spread);
               py = rand_coord(py, spread);
            end
            add_pick(px, py);
         end
         drain();
      end

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule
